@@ rtl/srp_pkg.sv @@
package srp_pkg;

    localparam int ASSOC  = 16;
    localparam int SLOT_W = $clog2(ASSOC);
    localparam int WAYS_W = $clog2(ASSOC + 1);

    localparam logic       OP_TOUCH    = 1'b0;
    localparam logic       OP_EVICT    = 1'b1;
    localparam logic [3:0] VICTIM_SLOT = 4'd0;

    typedef struct packed {
        logic touch;
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic              hand_bit;
        logic              out_free;
        logic [WAYS_W-1:0] ways;
    } t_dp_stat;

endpackage

@@ rtl/srp_req_if.sv @@
interface srp_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] way;

    modport source (output valid, output func, output way, input ready);
    modport sink (input valid, input func, input way, output ready);
endinterface

@@ rtl/srp_rsp_if.sv @@
interface srp_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_slot;
    logic [3:0] shift_count;

    modport source (output valid, output victim_slot, output shift_count, input ready);
    modport sink (input valid, input victim_slot, input shift_count, output ready);
endinterface

@@ rtl/srp_cfg_if.sv @@
interface srp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/srp_ctrl.sv @@
module srp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_func,
    output logic             o_req_ready,
    input  srp_pkg::t_dp_stat i_stat,
    output srp_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;
    logic   w_accept;

    assign w_accept    = i_req_valid && r_ready;
    assign o_req_ready = r_ready;

    always_comb begin
        n_state      = r_state;
        n_ready      = r_ready;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_func == srp_pkg::OP_EVICT) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                        n_ready     = 1'b0;
                    end else begin
                        o_cmd.touch = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.hand_bit) begin
                    o_cmd.step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                    n_ready      = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

endmodule

@@ rtl/srp_dp.sv @@
module srp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_way,
    input  srp_pkg::t_dp_cmd  i_cmd,
    output srp_pkg::t_dp_stat o_stat,
    srp_cfg_if.sink           i_cfg,
    srp_rsp_if.source         o_rsp
);

    logic [srp_pkg::ASSOC-1:0]  r_visited;
    logic [srp_pkg::ASSOC-1:0]  n_shifted;
    logic [srp_pkg::SLOT_W-1:0] r_hand;
    logic [srp_pkg::SLOT_W-1:0] r_scan;
    logic [srp_pkg::SLOT_W-1:0] n_scan;
    logic [srp_pkg::SLOT_W-1:0] n_start;
    logic [srp_pkg::WAYS_W-1:0] r_ways;
    logic [srp_pkg::WAYS_W-1:0] n_ways;
    logic                       r_out_valid;
    logic [3:0]                 r_shift;

    always_comb begin
        if (({1'b0, r_scan} + 1'b1) >= r_ways) begin
            n_scan = '0;
        end else begin
            n_scan = r_scan + 1'b1;
        end
        if ({1'b0, r_hand} >= r_ways) begin
            n_start = '0;
        end else begin
            n_start = r_hand;
        end
        if (i_cfg.data == '0) begin
            n_ways = srp_pkg::WAYS_W'(1);
        end else if (i_cfg.data > srp_pkg::WAYS_W'(srp_pkg::ASSOC)) begin
            n_ways = srp_pkg::WAYS_W'(srp_pkg::ASSOC);
        end else begin
            n_ways = i_cfg.data;
        end
        n_shifted = r_visited;
        for (int i = 1; i < srp_pkg::ASSOC; i++) begin
            if (i <= int'(r_scan)) begin
                n_shifted[i] = r_visited[i-1];
            end
        end
    end

    assign i_cfg.ready       = 1'b1;
    assign o_stat.hand_bit   = r_visited[r_scan];
    assign o_stat.out_free   = !r_out_valid || o_rsp.ready;
    assign o_stat.ways       = r_ways;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.victim_slot = srp_pkg::VICTIM_SLOT;
    assign o_rsp.shift_count = r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited   <= '0;
            r_hand      <= '0;
            r_scan      <= '0;
            r_ways      <= srp_pkg::WAYS_W'(srp_pkg::ASSOC);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_ways <= n_ways;
            end
            if (i_cmd.touch && ({1'b0, i_way} < r_ways)) begin
                r_visited[i_way] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_scan <= n_start;
            end
            if (i_cmd.step) begin
                r_visited[r_scan] <= 1'b0;
                r_scan            <= n_scan;
            end
            if (i_cmd.finish) begin
                r_visited   <= n_shifted;
                r_hand      <= n_scan;
                r_out_valid <= 1'b1;
                r_shift     <= 4'(r_scan);
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/sieve_replacement_policy.sv @@
// A touch request returns nothing; the next request is taken at once.
// An eviction raises the result valid once the hand has cleared the set visited bits it
// meets, one per cycle, at most 16, and stopped on a clear one; the next request is taken
// when the eviction finishes, later while a result waits.
// One request is in work at a time; a finished result waits in the output register.
// Reset is synchronous and active low: visited bits and hand clear, active ways returns to 16.
module sieve_replacement_policy (
    input logic       i_clk,
    input logic       i_rst_n,
    srp_req_if.sink   i_req,
    srp_rsp_if.source o_rsp,
    srp_cfg_if.sink   i_cfg
);

    srp_pkg::t_dp_cmd  w_cmd;
    srp_pkg::t_dp_stat w_stat;
    logic              w_req_ready;

    assign i_req.ready = w_req_ready;

    srp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    srp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_way   (i_req.way),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp)
    );

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ({1'b0, o_rsp.shift_count} < w_stat.ways))
        else $error("shift count at or beyond the ways in use");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step || w_cmd.finish) |-> !i_req.ready)
        else $error("request port ready while an eviction is in work");

    a_evict_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.func == srp_pkg::OP_EVICT) |=> !i_req.ready)
        else $error("eviction accepted without blocking the next request");

endmodule

@@ sim/tb_sieve_replacement_policy.sv @@
`timescale 1ns / 100ps

module tb_sieve_replacement_policy;

    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 10;
    localparam int SEGMENT_ITEMS  = 50;

    typedef enum logic [1:0] {
        ROW_TOUCH,
        ROW_EVICT,
        ROW_WAYS
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [4:0] value;
        logic       checked;
        logic [3:0] shift;
    } t_plan_row;

    typedef struct packed {
        logic [3:0] victim_slot;
        logic [3:0] shift_count;
    } t_eviction;

    logic i_clk;
    logic i_rst_n;

    srp_req_if req_if ();
    srp_rsp_if rsp_if ();
    srp_cfg_if cfg_if ();

    sieve_replacement_policy dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [srp_pkg::ASSOC-1:0] visited_q = '0;
    int                        hand_q    = 0;
    logic [4:0]                ways_reg  = 5'(srp_pkg::ASSOC);

    t_eviction expected_victims[$];

    int fail_count     = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    int         send_gap_pct[5] = '{0, 45, 0, 33, 0};
    int         recv_gap_pct[5] = '{0, 0, 45, 33, 0};
    logic [4:0] segment_ways[SEGMENTS] = '{5'd16, 5'd5, 5'd31, 5'd3, 5'd1,
                                           5'd12, 5'd0, 5'd20, 5'd9, 5'd16};

    t_plan_row smoke_plan[25] = '{
        '{ROW_EVICT, 5'd0,  1'b1, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b1, 4'd1},
        '{ROW_TOUCH, 5'd15, 1'b0, 4'd0},
        '{ROW_TOUCH, 5'd0,  1'b0, 4'd0},
        '{ROW_TOUCH, 5'd2,  1'b0, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b0, 4'd0},
        '{ROW_WAYS,  5'd0,  1'b0, 4'd0},
        '{ROW_TOUCH, 5'd1,  1'b0, 4'd0},
        '{ROW_EVICT, 5'd15, 1'b1, 4'd0},
        '{ROW_TOUCH, 5'd0,  1'b0, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b1, 4'd0},
        '{ROW_WAYS,  5'd4,  1'b0, 4'd0},
        '{ROW_TOUCH, 5'd0,  1'b0, 4'd0},
        '{ROW_TOUCH, 5'd1,  1'b0, 4'd0},
        '{ROW_TOUCH, 5'd2,  1'b0, 4'd0},
        '{ROW_TOUCH, 5'd3,  1'b0, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b1, 4'd0},
        '{ROW_WAYS,  5'd31, 1'b0, 4'd0},
        '{ROW_TOUCH, 5'd15, 1'b0, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b0, 4'd0},
        '{ROW_WAYS,  5'd16, 1'b0, 4'd0},
        '{ROW_TOUCH, 5'd7,  1'b0, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b0, 4'd0},
        '{ROW_WAYS,  5'd17, 1'b0, 4'd0},
        '{ROW_EVICT, 5'd0,  1'b0, 4'd0}
    };

    function automatic int ways_in_use();
        int n;
        n = ways_reg;
        if (n < 1) n = 1;
        if (n > srp_pkg::ASSOC) n = srp_pkg::ASSOC;
        return n;
    endfunction

    // The hand clears visited bits until it stands on a clear one, then the
    // bits below it move up one slot and the hand steps past the stop.
    function automatic logic [3:0] sieve_scan();
        int n;
        int h;
        int guard;
        n = ways_in_use();
        h = hand_q;
        if (h >= n) h = 0;
        guard = 0;
        while (guard <= n && visited_q[h]) begin
            visited_q[h] = 1'b0;
            h = (h + 1 >= n) ? 0 : h + 1;
            guard++;
        end
        for (int i = h; i > 0; i--) visited_q[i] = visited_q[i-1];
        hand_q = (h + 1 >= n) ? 0 : h + 1;
        return 4'(h);
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic issue(input logic f, input logic [3:0] w,
                         input logic checked = 1'b0, input logic [3:0] typed_shift = 4'd0);
        logic [3:0] scanned;
        req_if.valid <= 1'b1;
        req_if.func  <= f;
        req_if.way   <= w;
        do @(posedge i_clk); while (!req_if.ready);
        if (f == srp_pkg::OP_EVICT) begin
            scanned = sieve_scan();
            expected_victims.push_back(t_eviction'{srp_pkg::VICTIM_SLOT,
                                                   checked ? typed_shift : scanned});
        end else if (w < ways_in_use()) begin
            visited_q[w] = 1'b1;
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_victims.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ways(input logic [4:0] value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        ways_reg = value;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_eviction want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_victims.size() == 0) begin
                flag_error($sformatf("result with none pending: victim_slot %0d shift_count %0d",
                                     rsp_if.victim_slot, rsp_if.shift_count));
            end else begin
                want = expected_victims.pop_front();
                if (rsp_if.victim_slot !== want.victim_slot)
                    flag_error($sformatf("victim_slot: expected %0d, got %0d",
                                         want.victim_slot, rsp_if.victim_slot));
                if (rsp_if.shift_count !== want.shift_count)
                    flag_error($sformatf("shift_count: expected %0d, got %0d",
                                         want.shift_count, rsp_if.shift_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int pick;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.func  <= srp_pkg::OP_TOUCH;
        req_if.way   <= 4'd0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= 5'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (smoke_plan[r]) begin
            case (smoke_plan[r].kind)
                ROW_TOUCH: begin
                    issue(srp_pkg::OP_TOUCH, smoke_plan[r].value[3:0]);
                end
                ROW_EVICT: begin
                    issue(srp_pkg::OP_EVICT, smoke_plan[r].value[3:0], smoke_plan[r].checked,
                          smoke_plan[r].shift);
                end
                default: begin
                    write_ways(smoke_plan[r].value);
                end
            endcase
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            send_idle_pct  = send_gap_pct[seg / 2];
            recv_stall_pct = recv_gap_pct[seg / 2];
            write_ways((seg == 3 || seg == 8) ? 5'($urandom_range(31)) : segment_ways[seg]);
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
                if (seg == 0 && k == 20) hold_request = HOLD_CYCLES;
                n    = ways_in_use();
                pick = $urandom_range(99);
                if (pick < 35)
                    issue(srp_pkg::OP_EVICT, 4'($urandom_range(15)));
                else if (pick < 85)
                    issue(srp_pkg::OP_TOUCH, 4'($urandom_range(n - 1)));
                else
                    issue(srp_pkg::OP_TOUCH, 4'($urandom_range(15)));
                if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                    req_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
